// ----- rtl/sha256_stream_hasher_core_assert.svh -----
// Assertion macros for the port checker.
`ifndef SHA256_STREAM_HASHER_CORE_ASSERT_SVH
`define SHA256_STREAM_HASHER_CORE_ASSERT_SVH
// Assert that an implication holds on every rising clock edge outside reset.
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that an implication holds in the cycle after its antecedent.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/sha_pkg.sv -----
// Package: shared types, constants and the rotate helper for the SHA-256 core.
`timescale 1ns / 1ps
package sha_pkg;

  localparam logic MODE_ABSORB = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  // Work item between the front and the back: one byte or a finish request.
  typedef struct packed {
    logic       finish;
    logic [7:0] data;
  } cmd_t;

  localparam int unsigned QueueDepth = 2;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- rtl/sha256_stream_hasher_core.sv -----
// SHA-256 byte-stream hasher. Each absorbed byte is written into the block
// buffer; every 64th byte starts 64 rounds of the single round unit followed
// by an add step. A finish word takes a padding step, one or two compressions
// and then emits eight digest words, most significant first. A two-entry queue
// sits between intake and the round unit.
`timescale 1ns / 1ps
module sha256_stream_hasher_core
  import sha_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  sha_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  sha_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take), .cmd_i(cmd),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

// ----- rtl/sha_front.sv -----
// Front: accepts input words and queues them as byte or finish commands.
`timescale 1ns / 1ps
module sha_front
  import sha_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_data_i,
  output logic     cmd_valid_o,
  input  logic     cmd_take_i,
  output cmd_t     cmd_o
);

  cmd_t       fifo_q [QueueDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_stall_o  = (cnt_q == 2'(QueueDepth));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_take_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q].finish <= (in_data_i.mode == MODE_FINISH);
      fifo_q[wr_ptr_q].data   <= in_data_i.data_byte;
    end
  end

endmodule

// ----- rtl/sha_back.sv -----
// Back: block buffer, padding, 64-round compression and digest output.
`timescale 1ns / 1ps
module sha_back
  import sha_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_take_o,
  input  cmd_t      cmd_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_ROUND, ST_ADD, ST_EMIT
  } state_e;

  state_e      state_q;
  logic [31:0] w_q [16];     // message schedule window, also the block buffer
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [63:0] bits_q;
  logic [5:0]  fill_q;       // bytes in buffer
  logic [5:0]  rnd_q;
  logic        fin_q;        // final block being compressed
  logic        extra_q;      // length block still due after this one
  logic [2:0]  idx_q;
  logic        out_valid_q;
  out_word_t   out_q;

  logic [31:0] s0, s1, w_new, big0, big1, ch, maj, t1, t2;
  logic [31:0] wt;

  assign wt    = w_q[0];
  assign s0    = ror32(w_q[1], 7) ^ ror32(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1    = ror32(w_q[14], 17) ^ ror32(w_q[14], 19) ^ (w_q[14] >> 10);
  assign w_new = w_q[0] + s0 + w_q[9] + s1;
  assign big1  = ror32(v_q[4], 6) ^ ror32(v_q[4], 11) ^ ror32(v_q[4], 25);
  assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1    = v_q[7] + big1 + ch + ROUND_K[rnd_q] + wt;
  assign big0  = ror32(v_q[0], 2) ^ ror32(v_q[0], 13) ^ ror32(v_q[0], 22);
  assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2    = big0 + maj;

  assign cmd_take_o  = (state_q == ST_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bits_q      <= '0;
      fill_q      <= '0;
      rnd_q       <= '0;
      fin_q       <= 1'b0;
      extra_q     <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
    end else begin
      // outside emit, drop the held word once it is taken
      if (out_valid_q && !out_stall_i && (state_q != ST_EMIT)) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i && !out_valid_q) begin
            if (!cmd_i.finish) begin
              // drop the byte into its lane of the buffer
              w_q[fill_q[5:2]][8*(3-fill_q[1:0]) +: 8] <= cmd_i.data;
              bits_q <= bits_q + 64'd8;
              fill_q <= fill_q + 6'd1;
              if (fill_q == 6'd63) begin
                fin_q   <= 1'b0;
                extra_q <= 1'b0;
                rnd_q   <= '0;
                for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
                state_q <= ST_ROUND;
              end
            end else begin
              w_q[fill_q[5:2]][8*(3-fill_q[1:0]) +: 8] <= 8'h80;
              state_q <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          // clear bytes above the marker, add the length if room
          for (int b = 0; b < 64; b++) begin
            if ((6'(b) > fill_q) && ((b < 56) || (fill_q >= 6'd56)))
              w_q[b/4][8*(3-(b%4)) +: 8] <= 8'h00;
          end
          if (fill_q < 6'd56) begin
            w_q[14]  <= bits_q[63:32];
            w_q[15]  <= bits_q[31:0];
            extra_q  <= 1'b0;
          end else begin
            extra_q  <= 1'b1;
          end
          fin_q   <= 1'b1;
          rnd_q   <= '0;
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= w_new;
          v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
          rnd_q  <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) state_q <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          fill_q <= '0;
          if (fin_q && extra_q) begin
            for (int i = 0; i < 14; i++) w_q[i] <= '0;
            w_q[14] <= bits_q[63:32];
            w_q[15] <= bits_q[31:0];
            extra_q <= 1'b0;
            rnd_q   <= '0;
            for (int i = 0; i < 8; i++) v_q[i] <= h_q[i] + v_q[i];
            state_q <= ST_ROUND;
          end else if (fin_q) begin
            idx_q   <= '0;
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q       <= 1'b1;
            out_q.digest_word <= h_q[idx_q];
            out_q.word_index  <= idx_q;
            out_q.last_word   <= (idx_q == 3'd7);
            idx_q             <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
              bits_q  <= '0;
              fill_q  <= '0;
              fin_q   <= 1'b0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/sha_checker.sv -----
// Port checker for the SHA-256 hasher and its bind.
`timescale 1ns / 1ps
`include "sha256_stream_hasher_core_assert.svh"
module sha_checker
  import sha_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_word_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_data_o
);
  `SHA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `SHA_ASSERT_IMPL(a_last_idx, clk_i, rst_ni, out_valid_o, out_data_o.last_word == (out_data_o.word_index == 3'd7))
  `SHA_ASSERT_NEXT(a_idx_step, clk_i, rst_ni, out_valid_o && !out_stall_i && !out_data_o.last_word && $past(1'b1), !out_valid_o || out_data_o.word_index == $past(out_data_o.word_index) + 3'd1)
endmodule

bind sha256_stream_hasher_core sha_checker u_checker (.*);

// ----- sim/sha256_stream_hasher_core_tb.sv -----
// Testbench for the SHA-256 byte-stream hasher: directed table, then random messages.
`timescale 1ns / 1ps
module sha256_stream_hasher_core_tb;
  import sha_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_data_o;

  sha256_stream_hasher_core dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state
  logic [31:0] hash_state [8];
  logic [63:0] bit_total;
  logic [7:0]  block_buf [64];
  int unsigned buf_fill;

  out_word_t digest_q [$];
  int unsigned fail_count = 0;
  bit drive_done = 0;
  bit hold_off = 0;
  longint unsigned cycle_count = 0;

  // Typed-in check rows; digest word 0 of "" and of "abc" are well known.
  typedef struct {
    logic       mode;
    logic [7:0] data;
    bit         has_word0;
    logic [31:0] word0;
  } stim_row_t;

  stim_row_t stim_table [$];

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_init();
    hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                   32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    bit_total = '0;
    buf_fill = 0;
    foreach (block_buf[i]) block_buf[i] = '0;
  endfunction

  function automatic void hash_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] p, q, s0, s1;
    for (int t = 0; t < 16; t++)
      w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    v = hash_state;
    for (int t = 0; t < 64; t++) begin
      p = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
          + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
      q = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
          + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + p;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = p + q;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endfunction

  // Advance the predictor by one accepted word, queueing digest words.
  function automatic void hash_absorb(input in_word_t wd);
    int unsigned pos;
    out_word_t o;
    if (wd.mode == MODE_ABSORB) begin
      block_buf[buf_fill] = wd.data_byte;
      buf_fill++;
      bit_total += 64'd8;
      if (buf_fill == 64) begin
        hash_block();
        buf_fill = 0;
      end
      return;
    end
    pos = buf_fill;
    block_buf[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      for (int i = pos; i < 64; i++) block_buf[i] = '0;
      hash_block();
      pos = 0;
    end
    for (int i = pos; i < 56; i++) block_buf[i] = '0;
    for (int k = 0; k < 8; k++) block_buf[63-k] = bit_total[8*k +: 8];
    hash_block();
    for (int k = 0; k < 8; k++) begin
      o.digest_word = hash_state[k];
      o.word_index = k[2:0];
      o.last_word = (k == 7);
      digest_q.push_back(o);
    end
    hash_init();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Offer one word and hold it until accepted.
  task automatic send_word(input logic mode, input logic [7:0] data);
    in_valid_i <= 1'b1;
    in_data_i <= '{mode: mode, data_byte: data};
    do @(posedge clk_i); while (in_stall_o);
    hash_absorb('{mode: mode, data_byte: data});
    @(negedge clk_i);
  endtask

  task automatic send_gap();
    if ($urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  task automatic add_row(input logic mode, input logic [7:0] data, input bit has_w,
                         input logic [31:0] w0);
    stim_row_t r;
    r.mode = mode; r.data = data; r.has_word0 = has_w; r.word0 = w0;
    stim_table.push_back(r);
  endtask

  // Check digest words on the output side.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected word", out_data_o.digest_word, '0);
      end else begin
        out_word_t e;
        e = digest_q.pop_front();
        if (out_data_o.digest_word !== e.digest_word)
          report_mismatch("digest_word", out_data_o.digest_word, e.digest_word);
        if (out_data_o.word_index !== e.word_index)
          report_mismatch("word_index", 32'(out_data_o.word_index), 32'(e.word_index));
        if (out_data_o.last_word !== e.last_word)
          report_mismatch("last_word", 32'(out_data_o.last_word), 32'(e.last_word));
      end
    end
  end

  // Receiver stall pattern, with quiet stretches and one long hold-off.
  always @(negedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else if (cycle_count % 600 < 150) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 2) == 0);
  end

  initial begin
    repeat (400) @(negedge clk_i);
    hold_off = 1;
    repeat (1000) @(negedge clk_i);
    hold_off = 0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned len, sent;
    hash_init();
    // Empty message, then "abc", then a four-byte message
    add_row(MODE_FINISH, 8'hff, 1, 32'he3b0c442);
    add_row(MODE_ABSORB, "a", 0, '0);
    add_row(MODE_ABSORB, "b", 0, '0);
    add_row(MODE_ABSORB, "c", 0, '0);
    add_row(MODE_FINISH, 8'h00, 1, 32'hba7816bf);
    add_row(MODE_ABSORB, 8'h00, 0, '0);
    add_row(MODE_ABSORB, 8'hff, 0, '0);
    add_row(MODE_ABSORB, 8'h55, 0, '0);
    add_row(MODE_ABSORB, 8'haa, 0, '0);
    add_row(MODE_FINISH, 8'h5a, 0, '0);
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (stim_table[i]) begin
      if (stim_table[i].has_word0) begin
        send_word(stim_table[i].mode, stim_table[i].data);
        if (digest_q[$-7].digest_word !== stim_table[i].word0)
          report_mismatch("known digest", digest_q[$-7].digest_word, stim_table[i].word0);
      end else begin
        send_word(stim_table[i].mode, stim_table[i].data);
      end
      send_gap();
    end
    // Random messages: lengths around the padding boundaries and short ones
    sent = 0;
    while (sent < 300) begin
      case ($urandom_range(0, 4))
        0: len = $urandom_range(54, 58);
        1: len = $urandom_range(62, 66);
        2: len = $urandom_range(118, 122);
        default: len = $urandom_range(0, 20);
      endcase
      // trim the last message so the total stays near the target
      if (len > 299 - sent) len = 299 - sent;
      for (int b = 0; b < len; b++) begin
        send_word(MODE_ABSORB, $urandom_range(0, 255));
        if ($urandom_range(0, 15) == 0) send_gap();
      end
      send_word(MODE_FINISH, $urandom_range(0, 255));
      send_gap();
      sent += len + 1;
    end
    in_valid_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
